// ===== design/wdpm_pkg.sv =====
// Package: widths, symbol codes, register indexes and the character mapping.
package wdpm_pkg;

	localparam int MAX_PATTERN = 16;
	localparam int POS_BITS    = 32;
	localparam int SYM_BITS    = 3;
	localparam int HIST_DEPTH  = MAX_PATTERN - 1;
	localparam int LEN_BITS    = $clog2(MAX_PATTERN + 1);
	localparam int IDX_BITS    = $clog2(MAX_PATTERN);
	localparam int FILL_BITS   = $clog2(HIST_DEPTH + 1);
	localparam int CODES_BITS  = SYM_BITS * MAX_PATTERN;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = 48;
	localparam int CHAR_BITS   = 8;
	localparam int MATCH_BITS  = 32;

	typedef logic [SYM_BITS-1:0] sym_t;

	localparam sym_t SYM_A     = 3'd0;
	localparam sym_t SYM_C     = 3'd1;
	localparam sym_t SYM_G     = 3'd2;
	localparam sym_t SYM_T     = 3'd3;
	localparam sym_t SYM_N     = 3'd4;
	localparam sym_t SYM_OTHER = 3'd5;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_PATTERN_CODES  = 2'd0,
		CFG_WILDCARD_BITS  = 2'd1,
		CFG_PATTERN_LENGTH = 2'd2
	} cfg_idx_t;

	function automatic sym_t sym_of(input logic [CHAR_BITS-1:0] ch);
		sym_t s;
		case (ch)
			8'h41:   s = SYM_A;
			8'h43:   s = SYM_C;
			8'h47:   s = SYM_G;
			8'h54:   s = SYM_T;
			8'h4E:   s = SYM_N;
			default: s = SYM_OTHER;
		endcase
		return s;
	endfunction

endpackage

// ===== design/wdpm_ifs.sv =====
// Interfaces: text input, match output and configuration write channels.
interface wdpm_text_if;
	logic                             valid;
	logic                             ready;
	logic [wdpm_pkg::CHAR_BITS-1:0]   text_char;
	logic                             start_of_text;
	modport source (output valid, text_char, start_of_text, input ready);
	modport sink   (input valid, text_char, start_of_text, output ready);
endinterface

interface wdpm_match_if;
	logic                             valid;
	logic                             ready;
	logic [wdpm_pkg::MATCH_BITS-1:0]  match_start;
	modport source (output valid, match_start, input ready);
	modport sink   (input valid, match_start, output ready);
endinterface

interface wdpm_cfg_if;
	logic                                valid;
	logic                                ready;
	logic [wdpm_pkg::CFG_IDX_BITS-1:0]   index;
	logic [wdpm_pkg::CFG_DATA_BITS-1:0]  data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/wildcard_dna_pattern_matcher.sv =====
// Top level: streaming wildcard pattern matcher over the last pattern_length symbols.
// The window compare is a single registered pass; a match is written to the output
// buffer when its last character is taken; one char per cycle while text_in.ready.
// A two-entry output buffer (output register plus skid) keeps text_in ready while
// a result waits; text_in.ready drops only when both entries are full.
// Reset (arst_n low, asynchronous): position, fill count, buffer cleared; pattern
// registers return to codes 0, no wildcards, length 1. Symbol history is not reset.
module wildcard_dna_pattern_matcher (
	input  logic               clk,
	input  logic               arst_n,
	wdpm_text_if.sink          text_in,
	wdpm_match_if.source       match_out,
	wdpm_cfg_if.sink           cfg
);

	// Configuration registers
	logic [wdpm_pkg::CODES_BITS-1:0]  pattern_codes_q;
	logic [wdpm_pkg::MAX_PATTERN-1:0] wildcard_bits_q;
	logic [wdpm_pkg::LEN_BITS-1:0]    pattern_length_q;

	// Text state; history is most recent first, guarded by fill_count_q
	wdpm_pkg::sym_t                   symbol_history_q [wdpm_pkg::HIST_DEPTH];
	logic [wdpm_pkg::POS_BITS-1:0]    char_position_q;
	logic [wdpm_pkg::FILL_BITS-1:0]   fill_count_q;

	// Output buffer
	logic                             out_valid_q;
	logic [wdpm_pkg::MATCH_BITS-1:0]  out_data_q;
	logic                             skid_valid_q;
	logic [wdpm_pkg::MATCH_BITS-1:0]  skid_data_q;

	logic accept;
	logic fire_out;

	assign cfg.ready     = 1'b1;
	assign text_in.ready = !skid_valid_q;
	assign accept        = text_in.valid && text_in.ready;
	assign fire_out      = out_valid_q && match_out.ready;

	assign match_out.valid       = out_valid_q;
	assign match_out.match_start = out_data_q;

	// Configuration writes; indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_codes_q  <= '0;
			wildcard_bits_q  <= '0;
			pattern_length_q <= wdpm_pkg::LEN_BITS'(1);
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				wdpm_pkg::CFG_PATTERN_CODES:
					pattern_codes_q <= cfg.data[wdpm_pkg::CODES_BITS-1:0];
				wdpm_pkg::CFG_WILDCARD_BITS:
					wildcard_bits_q <= cfg.data[wdpm_pkg::MAX_PATTERN-1:0];
				wdpm_pkg::CFG_PATTERN_LENGTH:
					pattern_length_q <= cfg.data[wdpm_pkg::LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// ---- Per-character window compare ----
	wdpm_pkg::sym_t                   cur_sym;
	wdpm_pkg::sym_t                   win [wdpm_pkg::MAX_PATTERN];
	logic [wdpm_pkg::FILL_BITS-1:0]   fill_eff;     // history depth seen by this char
	logic [wdpm_pkg::POS_BITS-1:0]    pos_base;
	logic [wdpm_pkg::POS_BITS-1:0]    pos_next;
	logic [wdpm_pkg::LEN_BITS-1:0]    len_eff;      // length clamped to MAX_PATTERN
	logic [wdpm_pkg::IDX_BITS-1:0]    len_m1;
	logic [wdpm_pkg::MAX_PATTERN-1:0] pos_ok;
	logic                             len_fits;
	logic                             hit;
	logic [wdpm_pkg::MATCH_BITS-1:0]  start_pos;

	always_comb begin
		cur_sym  = wdpm_pkg::sym_of(text_in.text_char);
		fill_eff = text_in.start_of_text ? '0 : fill_count_q;
		pos_base = text_in.start_of_text ? '0 : char_position_q;
		// saturating position count
		pos_next = (&pos_base) ? pos_base : pos_base + wdpm_pkg::POS_BITS'(1);

		len_eff = (pattern_length_q > wdpm_pkg::LEN_BITS'(wdpm_pkg::MAX_PATTERN)) ?
			wdpm_pkg::LEN_BITS'(wdpm_pkg::MAX_PATTERN) : pattern_length_q;
		len_m1  = wdpm_pkg::IDX_BITS'(len_eff - wdpm_pkg::LEN_BITS'(1));
		// length must be nonzero and no longer than the symbols seen so far
		len_fits = (len_eff != '0) &&
			(len_eff <= wdpm_pkg::LEN_BITS'(fill_eff) + wdpm_pkg::LEN_BITS'(1));

		win[0] = cur_sym;
		for (int k = 1; k < wdpm_pkg::MAX_PATTERN; k++) begin
			win[k] = symbol_history_q[k-1];
		end

		// pattern position k lines up with window slot len-1-k
		for (int k = 0; k < wdpm_pkg::MAX_PATTERN; k++) begin
			pos_ok[k] = (wdpm_pkg::LEN_BITS'(k) >= len_eff) || wildcard_bits_q[k] ||
				(pattern_codes_q[wdpm_pkg::SYM_BITS*k +: wdpm_pkg::SYM_BITS] ==
				 win[len_m1 - wdpm_pkg::IDX_BITS'(k)]);
		end

		hit       = len_fits && (&pos_ok);
		start_pos = wdpm_pkg::MATCH_BITS'(pos_next - wdpm_pkg::POS_BITS'(len_eff)
			+ wdpm_pkg::POS_BITS'(1));
	end

	// Text state update on each accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_position_q <= '0;
			fill_count_q    <= '0;
		end else if (accept) begin
			char_position_q <= pos_next;
			if (fill_eff != wdpm_pkg::FILL_BITS'(wdpm_pkg::HIST_DEPTH))
				fill_count_q <= fill_eff + wdpm_pkg::FILL_BITS'(1);
			else
				fill_count_q <= fill_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			symbol_history_q[0] <= cur_sym;
			for (int k = 1; k < wdpm_pkg::HIST_DEPTH; k++) begin
				symbol_history_q[k] <= symbol_history_q[k-1];
			end
		end
	end

	// ---- Output buffer: pop, refill from skid, then push new match ----
	logic                            o_v_n, s_v_n;
	logic [wdpm_pkg::MATCH_BITS-1:0] o_d_n, s_d_n;

	always_comb begin
		o_v_n = out_valid_q && !fire_out;
		o_d_n = out_data_q;
		s_v_n = skid_valid_q;
		s_d_n = skid_data_q;
		if (fire_out && skid_valid_q) begin
			o_v_n = 1'b1;
			o_d_n = skid_data_q;
			s_v_n = 1'b0;
		end
		if (accept && hit) begin
			if (!o_v_n) begin
				o_v_n = 1'b1;
				o_d_n = start_pos;
			end else begin
				s_v_n = 1'b1;
				s_d_n = start_pos;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			out_valid_q  <= o_v_n;
			skid_valid_q <= s_v_n;
		end
	end

	always_ff @(posedge clk) begin
		out_data_q  <= o_d_n;
		skid_data_q <= s_d_n;
	end

endmodule
